// ===== rtl/pgv_pkg.sv =====
// Shared types and constants of the panel gamma image generator.
`timescale 1ns / 1ps
package pgv_pkg;

  localparam int unsigned PTS = 9;
  localparam logic [3:0] TOP_PT = 4'd8;
  localparam logic [9:0] MUL_TOP = 10'd860;
  localparam logic [9:0] MUL_LOW = 10'd320;
  localparam logic [15:0] OFS_TOP = 16'd72;
  localparam logic [7:0] OFS_LOW = 8'd64;
  localparam logic [3:0] DIV_STEPS = 4'd10;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_REF = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_DOMAIN = 2'd3;

  localparam logic [2:0] REG_TOP = 3'd0;
  localparam logic [2:0] REG_BLK_R = 3'd1;
  localparam logic [2:0] REG_BLK_G = 3'd2;
  localparam logic [2:0] REG_BLK_B = 3'd3;
  localparam logic [2:0] REG_VT_R = 3'd4;
  localparam logic [2:0] REG_VT_G = 3'd5;
  localparam logic [2:0] REG_VT_B = 3'd6;

  typedef struct packed {
    logic [3:0] point_sel;
    logic [15:0] gray_index;
    logic signed [23:0] target_red;
    logic signed [23:0] target_green;
    logic signed [23:0] target_blue;
    logic frame_end;
  } item_t;

  typedef struct packed {
    logic [5:0] byte_pos;
    logic [7:0] byte_val;
    logic [1:0] status;
    logic run_end;
  } res_t;

  typedef struct packed {
    logic start;
    logic top_pt;
  } lane_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX,
    S_CHK,
    S_LOAD,
    S_WAIT,
    S_EMIT,
    S_VT,
    S_ERR
  } state_e;

endpackage

// ===== rtl/pgv_lane.sv =====
// One color lane: domain check, constant scaling and a ten-step restoring divider.
`timescale 1ns / 1ps
module pgv_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pgv_pkg::lane_cmd_t cmd_i,
  input  logic [22:0]        top_i,
  input  logic [22:0]        ref_i,
  input  logic signed [23:0] t_i,
  input  logic signed [23:0] th_i,
  output logic [1:0]         err_o,
  output logic               done_o,
  output logic [9:0]         q_o
);

  logic signed [25:0] t_s, th_s, ref_s, top_s, num_s, den_s;
  logic [24:0] num_q, den_q;
  logic top_pt_q, mul_q, done_q;
  logic [34:0] rem_q, dsh_q, prod;
  logic [9:0] q_q, kmul;
  logic [3:0] cnt_q;
  logic ge;

  assign t_s = 26'(t_i);
  assign th_s = 26'(th_i);
  assign ref_s = {3'b000, ref_i};
  assign top_s = {3'b000, top_i};
  assign num_s = (cmd_i.top_pt ? top_s : ref_s) - t_s;
  assign den_s = ref_s - th_s;

  always_comb begin
    err_o = pgv_pkg::STAT_OK;
    if (cmd_i.top_pt) begin
      if (t_s < 26'sd0 || t_s > top_s) err_o = pgv_pkg::STAT_DOMAIN;
    end else begin
      if (t_s > ref_s || th_s >= ref_s || num_s > den_s) err_o = pgv_pkg::STAT_DOMAIN;
      else if (num_s == den_s) err_o = pgv_pkg::STAT_RANGE;
    end
  end

  assign kmul = top_pt_q ? pgv_pkg::MUL_TOP : pgv_pkg::MUL_LOW;
  assign prod = 35'(num_q) * 35'(kmul);
  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q <= num_s[24:0];
      den_q <= cmd_i.top_pt ? top_s[24:0] : den_s[24:0];
      top_pt_q <= cmd_i.top_pt;
    end
    if (mul_q) begin
      rem_q <= prod;
      dsh_q <= {1'b0, den_q, 9'b0};
      q_q <= '0;
    end else if (cnt_q != 4'd0) begin
      if (ge) rem_q <= rem_q - dsh_q;
      q_q <= {q_q[8:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q <= 1'b0;
      cnt_q <= 4'd0;
      done_q <= 1'b0;
    end else begin
      mul_q <= cmd_i.start;
      done_q <= (cnt_q == 4'd1);
      if (mul_q) cnt_q <= pgv_pkg::DIV_STEPS;
      else if (cnt_q != 4'd0) cnt_q <= cnt_q - 4'd1;
    end
  end

  assign done_o = done_q;
  assign q_o = q_q;

endmodule

// ===== rtl/pgv_merge.sv =====
// Merge stage: picks the first lane error and formats lane quotients into image bytes.
`timescale 1ns / 1ps
module pgv_merge (
  input  logic             clk_i,
  input  logic             cap_i,
  input  logic             top_pt_i,
  input  logic [2:0]       sel_i,
  input  logic [2:0][1:0]  err_i,
  input  logic [2:0][9:0]  q_i,
  output logic [1:0]       status_o,
  output logic [7:0]       byte_o
);

  logic [2:0][15:0] code_q;

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      for (int c = 0; c < 3; c++) begin
        if (top_pt_i) code_q[c] <= {6'b0, q_i[c]} - pgv_pkg::OFS_TOP;
        else code_q[c] <= {8'b0, q_i[c][7:0] - pgv_pkg::OFS_LOW};
      end
    end
  end

  always_comb begin
    if (err_i[0] != pgv_pkg::STAT_OK) status_o = err_i[0];
    else if (err_i[1] != pgv_pkg::STAT_OK) status_o = err_i[1];
    else status_o = err_i[2];
  end

  always_comb begin
    if (top_pt_i) byte_o = sel_i[0] ? code_q[sel_i[2:1]][7:0] : code_q[sel_i[2:1]][15:8];
    else byte_o = code_q[sel_i[1:0]][7:0];
  end

endmodule

// ===== rtl/panel_gamma_from_voltages_core.sv =====
// Top level of the panel gamma register image generator.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------
//  item in  | start & !busy       | item_i (pgv_pkg::item_t)
//  config   | cfg_valid_i & ready | cfg_index_i, cfg_data_i
//  result   | res_valid_o strobe  | result_o (pgv_pkg::res_t)
//
// An item without frame_end is stored (if point_sel names a point) and busy stays low.
// A frame_end item starts a run: index checks step through the points in
// order, target checks step back from the top point, then each point is
// scaled, divided by the lanes' ten-step divider and its bytes emitted.
// Reset clears control state and registers; point storage holds until written.
// Results show for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps
module panel_gamma_from_voltages_core #(
  parameter int unsigned GRAY_LEVELS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pgv_pkg::item_t item_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [22:0]    cfg_data_i,
  output logic           res_valid_o,
  output pgv_pkg::res_t  result_o
);

  pgv_pkg::state_e state_q, state_d;
  logic [22:0] top_q;
  logic [2:0][22:0] blk_q;
  logic [2:0][7:0] vt_q;
  logic [8:0][2:0][23:0] tgt_q;
  logic [8:0][15:0] idx_q;
  logic [8:0] loaded_q, sel_bit;
  logic [3:0] p_q;
  logic [15:0] prev_q, idx_cur;
  logic [2:0][23:0] th_q;
  logic [2:0] b_q;
  logic [5:0] pos_q;
  logic [1:0] st_q;
  logic acc, go, idx_err, last_b, top_pt;
  logic res_v_d;
  pgv_pkg::res_t res_d;
  pgv_pkg::lane_cmd_t cmd;
  logic [2:0][1:0] lane_err;
  logic [2:0][9:0] lane_q;
  logic [2:0] lane_done;
  logic [1:0] mrg_st;
  logic [7:0] mrg_byte;

  assign acc = start && !busy;
  assign go = acc && item_i.frame_end;
  assign busy = (state_q != pgv_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign sel_bit = (item_i.point_sel <= pgv_pkg::TOP_PT) ? (9'd1 << item_i.point_sel) : 9'd0;
  assign top_pt = (p_q == pgv_pkg::TOP_PT);
  assign idx_cur = idx_q[p_q];
  assign idx_err = ({1'b0, idx_cur} >= 17'(GRAY_LEVELS)) || (p_q != 4'd0 && idx_cur <= prev_q);
  assign last_b = top_pt ? (b_q == 3'd5) : (b_q == 3'd2);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pgv_pkg::S_IDLE: begin
        if (go) begin
          if (top_q == 23'd0 || (loaded_q | sel_bit) != 9'h1FF) state_d = pgv_pkg::S_ERR;
          else state_d = pgv_pkg::S_IDX;
        end
      end
      pgv_pkg::S_IDX: begin
        if (idx_err) state_d = pgv_pkg::S_ERR;
        else if (top_pt) state_d = pgv_pkg::S_CHK;
      end
      pgv_pkg::S_CHK: begin
        if (mrg_st != pgv_pkg::STAT_OK) state_d = pgv_pkg::S_ERR;
        else if (p_q == 4'd0) state_d = pgv_pkg::S_LOAD;
      end
      pgv_pkg::S_LOAD: state_d = pgv_pkg::S_WAIT;
      pgv_pkg::S_WAIT: if (lane_done[0]) state_d = pgv_pkg::S_EMIT;
      pgv_pkg::S_EMIT: begin
        if (last_b) state_d = (p_q == 4'd0) ? pgv_pkg::S_VT : pgv_pkg::S_LOAD;
      end
      pgv_pkg::S_VT: if (b_q == 3'd2) state_d = pgv_pkg::S_IDLE;
      pgv_pkg::S_ERR: state_d = pgv_pkg::S_IDLE;
      default: state_d = pgv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.top_pt = top_pt;
    res_v_d = 1'b0;
    res_d = '0;
    case (state_q)
      pgv_pkg::S_LOAD: cmd.start = 1'b1;
      pgv_pkg::S_EMIT: begin
        res_v_d = 1'b1;
        res_d.byte_pos = pos_q;
        res_d.byte_val = mrg_byte;
      end
      pgv_pkg::S_VT: begin
        res_v_d = 1'b1;
        res_d.byte_pos = pos_q;
        res_d.byte_val = vt_q[b_q[1:0]];
        res_d.run_end = (b_q == 3'd2);
      end
      pgv_pkg::S_ERR: begin
        res_v_d = 1'b1;
        res_d.status = st_q;
        res_d.run_end = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc && item_i.point_sel <= pgv_pkg::TOP_PT) begin
      idx_q[item_i.point_sel] <= item_i.gray_index;
      tgt_q[item_i.point_sel] <= {item_i.target_blue, item_i.target_green, item_i.target_red};
    end
    result_o <= res_d;
    case (state_q)
      pgv_pkg::S_IDLE: begin
        p_q <= 4'd0;
        pos_q <= 6'd0;
        st_q <= (top_q == 23'd0) ? pgv_pkg::STAT_REF : pgv_pkg::STAT_DOMAIN;
      end
      pgv_pkg::S_IDX: begin
        prev_q <= idx_cur;
        st_q <= ({1'b0, idx_cur} >= 17'(GRAY_LEVELS)) ? pgv_pkg::STAT_RANGE
                                                       : pgv_pkg::STAT_DOMAIN;
        if (!top_pt) p_q <= p_q + 4'd1;
      end
      pgv_pkg::S_CHK: begin
        th_q <= tgt_q[p_q];
        st_q <= mrg_st;
        p_q <= (p_q == 4'd0) ? pgv_pkg::TOP_PT : p_q - 4'd1;
      end
      pgv_pkg::S_LOAD: begin
        th_q <= tgt_q[p_q];
        b_q <= 3'd0;
      end
      pgv_pkg::S_EMIT: begin
        pos_q <= pos_q + 6'd1;
        b_q <= last_b ? 3'd0 : b_q + 3'd1;
        if (last_b && p_q != 4'd0) p_q <= p_q - 4'd1;
      end
      pgv_pkg::S_VT: begin
        pos_q <= pos_q + 6'd1;
        b_q <= b_q + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pgv_pkg::S_IDLE;
      loaded_q <= 9'd0;
      res_valid_o <= 1'b0;
      top_q <= '0;
      blk_q <= '0;
      vt_q <= '0;
    end else begin
      state_q <= state_d;
      res_valid_o <= res_v_d;
      if (acc) loaded_q <= item_i.frame_end ? 9'd0 : (loaded_q | sel_bit);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pgv_pkg::REG_TOP: top_q <= cfg_data_i;
          pgv_pkg::REG_BLK_R: blk_q[0] <= cfg_data_i;
          pgv_pkg::REG_BLK_G: blk_q[1] <= cfg_data_i;
          pgv_pkg::REG_BLK_B: blk_q[2] <= cfg_data_i;
          pgv_pkg::REG_VT_R: vt_q[0] <= cfg_data_i[7:0];
          pgv_pkg::REG_VT_G: vt_q[1] <= cfg_data_i[7:0];
          pgv_pkg::REG_VT_B: vt_q[2] <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    pgv_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .top_i  (top_q),
      .ref_i  ((p_q == 4'd0) ? top_q : blk_q[c]),
      .t_i    (tgt_q[p_q][c]),
      .th_i   (th_q[c]),
      .err_o  (lane_err[c]),
      .done_o (lane_done[c]),
      .q_o    (lane_q[c])
    );
  end

  pgv_merge u_merge (
    .clk_i    (clk_i),
    .cap_i    (lane_done[0]),
    .top_pt_i (top_pt),
    .sel_i    (b_q),
    .err_i    (lane_err),
    .q_i      (lane_q),
    .status_o (mrg_st),
    .byte_o   (mrg_byte)
  );

endmodule

// ===== rtl/pgv_checker.sv =====
// Port-level assertions for the gamma image generator, with its bind.
`timescale 1ns / 1ps
module pgv_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input pgv_pkg::item_t item_i,
  input logic          res_valid_o,
  input pgv_pkg::res_t result_o
);

  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && result_o.status != pgv_pkg::STAT_OK |-> result_o.run_end)
    else $error("error result without run_end");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && result_o.status != pgv_pkg::STAT_OK |->
      result_o.byte_pos == 6'd0 && result_o.byte_val == 8'd0)
    else $error("error result carries data");

  a_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.frame_end |=> busy)
    else $error("frame end transfer did not start a run");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !result_o.run_end |-> busy)
    else $error("run stopped before its last byte");

endmodule

bind panel_gamma_from_voltages_core pgv_checker u_pgv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .item_i      (item_i),
  .res_valid_o (res_valid_o),
  .result_o    (result_o)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the panel gamma image generator.
`timescale 1ns / 1ps
module testbench;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int GRAY = 256;
  localparam int QUIET_LIMIT = 4000;
  localparam int TOP_MAX = 8388607;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  pgv_pkg::item_t item_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [22:0] cfg_data_i = '0;
  logic res_valid_o;
  pgv_pkg::res_t result_o;

  panel_gamma_from_voltages_core i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .res_valid_o(res_valid_o), .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  // model state
  logic [22:0] top_v;
  logic [22:0] black_v [3];
  logic [7:0] vt_v [3];
  logic signed [23:0] tgt [9][3];
  logic [15:0] gidx [9];
  logic [8:0] loaded;
  logic [7:0] img [33];

  pgv_pkg::res_t image_q [$];
  int errors = 0;
  int quiet = 0;
  int n_items = 0;

  typedef struct {
    pgv_pkg::item_t it;
    bit typed;
    logic [1:0] st;
  } row_t;
  row_t rows [$];

  function automatic pgv_pkg::item_t mk(int sel, int idx, int r, int g, int b, bit fe);
    pgv_pkg::item_t it;
    it.point_sel = sel[3:0];
    it.gray_index = idx[15:0];
    it.target_red = r[23:0];
    it.target_green = g[23:0];
    it.target_blue = b[23:0];
    it.frame_end = fe;
    return it;
  endfunction

  function automatic logic [1:0] build_image();
    longint top, t, th, rv, num, den, code;
    logic [15:0] enc;
    int p;
    top = longint'(top_v);
    if (top <= 0) return pgv_pkg::STAT_REF;
    if (loaded != 9'h1FF) return pgv_pkg::STAT_DOMAIN;
    for (int q = 0; q < 9; q++) begin
      if (gidx[q] >= GRAY) return pgv_pkg::STAT_RANGE;
      if (q > 0 && gidx[q] <= gidx[q-1]) return pgv_pkg::STAT_DOMAIN;
    end
    for (int c = 0; c < 3; c++) begin
      t = longint'(tgt[8][c]);
      if (t < 0 || t > top) return pgv_pkg::STAT_DOMAIN;
      code = (top - t) * 860 / top - 72;
      enc = code[15:0];
      img[2*c] = enc[15:8];
      img[2*c+1] = enc[7:0];
    end
    for (int i = 0; i < 8; i++) begin
      p = 7 - i;
      for (int c = 0; c < 3; c++) begin
        rv = (p == 0) ? top : longint'(black_v[c]);
        t = longint'(tgt[p][c]);
        th = longint'(tgt[p+1][c]);
        if (t > rv || th >= rv) return pgv_pkg::STAT_DOMAIN;
        num = rv - t;
        den = rv - th;
        if (den <= 0 || num < 0 || num > den) return pgv_pkg::STAT_DOMAIN;
        code = num * 320 / den - 64;
        if (code > 255) return pgv_pkg::STAT_RANGE;
        img[6 + i*3 + c] = code[7:0];
      end
    end
    for (int c = 0; c < 3; c++) img[30+c] = vt_v[c];
    return pgv_pkg::STAT_OK;
  endfunction

  // returns results caused by one transfer, in order
  task automatic predict_image(input pgv_pkg::item_t it, output pgv_pkg::res_t res [$]);
    logic [1:0] st;
    pgv_pkg::res_t r;
    res = {};
    if (it.point_sel < 9) begin
      gidx[it.point_sel] = it.gray_index;
      tgt[it.point_sel][0] = it.target_red;
      tgt[it.point_sel][1] = it.target_green;
      tgt[it.point_sel][2] = it.target_blue;
      loaded[it.point_sel] = 1'b1;
    end
    if (!it.frame_end) return;
    st = build_image();
    loaded = '0;
    if (st != pgv_pkg::STAT_OK) begin
      r = '{byte_pos: 6'd0, byte_val: 8'd0, status: st, run_end: 1'b1};
      res.push_back(r);
    end else begin
      for (int k = 0; k < 33; k++) begin
        r = '{byte_pos: k[5:0], byte_val: img[k], status: pgv_pkg::STAT_OK,
              run_end: k == 32};
        res.push_back(r);
      end
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input pgv_pkg::item_t it, input bit typed, input logic [1:0] st,
                      input int gap);
    pgv_pkg::res_t res [$];
    pgv_pkg::res_t r;
    @(negedge clk_i);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_image(it, res);
    if (typed) begin
      r = '{byte_pos: 6'd0, byte_val: 8'd0, status: st, run_end: 1'b1};
      image_q.push_back(r);
    end else begin
      foreach (res[k]) image_q.push_back(res[k]);
    end
    n_items++;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (image_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int data);
    logic [22:0] d;
    d = data[22:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pgv_pkg::REG_TOP: top_v = d;
      pgv_pkg::REG_BLK_R: black_v[0] = d;
      pgv_pkg::REG_BLK_G: black_v[1] = d;
      pgv_pkg::REG_BLK_B: black_v[2] = d;
      pgv_pkg::REG_VT_R: vt_v[0] = d[7:0];
      pgv_pkg::REG_VT_G: vt_v[1] = d[7:0];
      pgv_pkg::REG_VT_B: vt_v[2] = d[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input int mode);
    int top;
    int blk;
    top = (mode == 0) ? TOP_MAX : (mode == 1) ? 0 : $urandom_range(64, TOP_MAX);
    write_reg(pgv_pkg::REG_TOP, top);
    for (int c = 0; c < 3; c++) begin
      if (mode == 0) blk = TOP_MAX;
      else if (mode == 1) blk = 0;
      else if ($urandom_range(0, 9) == 0) blk = $urandom_range(0, TOP_MAX);
      else blk = $urandom_range(32, top);
      write_reg(pgv_pkg::REG_BLK_R + c[2:0], blk);
    end
    for (int c = 0; c < 3; c++)
      write_reg(pgv_pkg::REG_VT_R + c[2:0], $urandom_range(0, TOP_MAX));
    if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, $urandom_range(0, TOP_MAX));
  endtask

  task automatic run_frame();
    pgv_pkg::item_t pts [$];
    pgv_pkg::item_t tmp;
    int tv [9][3];
    int kind, m, j, lo, hi;
    bit burst;
    kind = $urandom_range(0, 11);
    burst = $urandom_range(0, 3) == 0;
    for (int c = 0; c < 3; c++) begin
      m = (top_v < black_v[c]) ? int'(top_v) : int'(black_v[c]);
      if (m < 16) begin
        for (int p = 0; p < 9; p++) tv[p][c] = $urandom_range(0, 32'hFFFFFF);
      end else begin
        tv[8][c] = $urandom_range(0, m - 9);
        for (int p = 7; p >= 1; p--)
          tv[p][c] = $urandom_range(tv[p+1][c] + 1, black_v[c] - p);
        lo = tv[1][c] + 1;
        hi = int'(top_v);
        tv[0][c] = (lo > hi) ? hi : $urandom_range(lo, hi);
      end
    end
    if (kind == 9) begin
      j = $urandom_range(0, 7);
      tv[j] = tv[j+1];
    end
    for (int p = 0; p < 9; p++)
      pts.push_back(mk(p, p * 28 + $urandom_range(0, 27), tv[p][0], tv[p][1], tv[p][2], 0));
    if (kind == 6) begin
      j = $urandom_range(0, 8);
      pts[j].target_red = 24'($urandom_range(0, 32'hFFFFFF));
      pts[j].target_green = 24'($urandom_range(0, 32'hFFFFFF));
      pts[j].target_blue = 24'($urandom_range(0, 32'hFFFFFF));
    end
    if (kind == 7) pts[$urandom_range(0, 8)].gray_index = 16'($urandom_range(0, 65535));
    for (int p = 8; p > 0; p--) begin
      j = $urandom_range(0, p);
      tmp = pts[p];
      pts[p] = pts[j];
      pts[j] = tmp;
    end
    if (kind == 8) pts.delete($urandom_range(0, 8));
    if ($urandom_range(0, 3) == 0)
      pts.insert($urandom_range(0, pts.size() - 1),
                 mk($urandom_range(9, 15), $urandom_range(0, 65535), $urandom_range(0, 32'hFFFFFF),
                    $urandom_range(0, 32'hFFFFFF), $urandom_range(0, 32'hFFFFFF), 0));
    if (kind == 5)
      pts.push_back(mk($urandom_range(9, 15), $urandom_range(0, 65535), 0, 0, 0, 1));
    else
      pts[pts.size() - 1].frame_end = 1'b1;
    foreach (pts[k]) send(pts[k], 0, pgv_pkg::STAT_OK, burst ? 0 : pick_gap());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
      if (res_valid_o) begin
        if (image_q.size() == 0) begin
          $error("unexpected result pos=%0d val=%0h", result_o.byte_pos, result_o.byte_val);
          errors++;
        end else begin
          if (result_o.byte_pos !== image_q[0].byte_pos) begin
            $error("byte_pos exp %0d got %0d", image_q[0].byte_pos, result_o.byte_pos);
            errors++;
          end
          if (result_o.byte_val !== image_q[0].byte_val) begin
            $error("byte_val exp %0h got %0h", image_q[0].byte_val, result_o.byte_val);
            errors++;
          end
          if (result_o.status !== image_q[0].status) begin
            $error("status exp %0d got %0d", image_q[0].status, result_o.status);
            errors++;
          end
          if (result_o.run_end !== image_q[0].run_end) begin
            $error("run_end exp %0d got %0d", image_q[0].run_end, result_o.run_end);
            errors++;
          end
          image_q.pop_front();
        end
      end
    end
  end

  initial begin
    int nframes;
    top_v = '0;
    black_v = '{default: '0};
    vt_v = '{default: '0};
    loaded = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: missing reference, missing points, extremes, gray index out of range
    rows.push_back('{mk(15, 0, 0, 0, 0, 1), 1, pgv_pkg::STAT_REF});
    foreach (rows[k]) send(rows[k].it, rows[k].typed, rows[k].st, 1);
    rows = {};
    wait_idle();
    configure(0);
    rows.push_back('{mk(0, 0, 0, 0, 0, 1), 1, pgv_pkg::STAT_DOMAIN});
    for (int p = 0; p < 9; p++)
      rows.push_back('{mk(p, p == 8 ? 255 : p, p == 0 ? TOP_MAX : 8 - p, p == 0 ? TOP_MAX : 8 - p,
                          p == 0 ? TOP_MAX : 8 - p, p == 8), 0, pgv_pkg::STAT_OK});
    for (int p = 0; p < 9; p++)
      rows.push_back('{mk(p, p == 8 ? 256 : p, 8388607 - p, 100, 200, p == 8), p == 8,
                       pgv_pkg::STAT_RANGE});
    rows.push_back('{mk(12, 65535, -8388608, -1, 8388607, 1), 1, pgv_pkg::STAT_DOMAIN});
    foreach (rows[k]) send(rows[k].it, rows[k].typed, rows[k].st, pick_gap());

    nframes = 0;
    while (n_items < 260) begin
      if (nframes % 5 == 0) begin
        wait_idle();
        configure(nframes == 20 ? 1 : ($urandom_range(0, 5) == 0 ? 0 : 2));
      end
      run_frame();
      nframes++;
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (image_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
